@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the attitude update block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define DCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/dcm_pkg.sv @@
// ----------------------------------------------------------------------------
// dcm_pkg
// Types, constants and fixed-point helpers of the DCM attitude update block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcm_pkg;

  // Fraction bits of the sample period register (10..16).
  localparam int SampleBits = 16;
  localparam int ThShift    = SampleBits - 14;
  localparam int ThDown     = (ThShift > 0) ? ThShift : 1;
  localparam int ThUp       = (ThShift > 0) ? 0 : -ThShift;

  typedef logic signed [79:0] wide_t;
  typedef logic [6:0]         step_t;

  localparam wide_t Max31   = 80'sd2147483647;
  localparam wide_t Min32   = -80'sd2147483648;
  localparam wide_t Max40   = 80'sd549755813887;
  localparam wide_t Min40   = -80'sd549755813888;
  localparam wide_t ErrLim  = 80'sd65536000;
  localparam wide_t Three30 = 80'sd3221225472;

  localparam logic signed [32:0] FiltOld = 33'sd39322;
  localparam logic signed [32:0] FiltNew = 33'sd26214;

  // Micro-step map of one request.
  localparam step_t StepAx   = 7'd0;
  localparam step_t StepUpd  = 7'd12;
  localparam step_t StepErr  = 7'd30;
  localparam step_t StepRow  = 7'd33;
  localparam step_t StepCrs  = 7'd39;
  localparam step_t StepNrm  = 7'd45;
  localparam step_t StepEc   = 7'd63;
  localparam step_t StepGain = 7'd69;
  localparam step_t StepLast = 7'd74;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_COPY = 4'b0100,
    ST_DONE = 4'b1000
  } st_e;

  typedef enum logic [2:0] {
    SEG_AX   = 3'd0,
    SEG_UPD  = 3'd1,
    SEG_ERR  = 3'd2,
    SEG_ROW  = 3'd3,
    SEG_CRS  = 3'd4,
    SEG_NRM  = 3'd5,
    SEG_EC   = 3'd6,
    SEG_GAIN = 3'd7
  } seg_e;

  typedef enum logic [1:0] {
    CFG_GYRO_GAIN     = 2'd0,
    CFG_SAMPLE_PERIOD = 2'd1,
    CFG_KP            = 2'd2,
    CFG_KI            = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } out_rsp_t;

  // Round half up, then arithmetic shift.
  function automatic wide_t rnd(wide_t v, int unsigned s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > Max31) return 32'sh7fff_ffff;
    if (v < Min32) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  function automatic logic signed [39:0] sat40(wide_t v);
    if (v > Max40) return 40'sh7f_ffff_ffff;
    if (v < Min40) return 40'sh80_0000_0000;
    return 40'(v);
  endfunction

  function automatic logic signed [26:0] clamp_err(wide_t v);
    if (v > ErrLim) return 27'(ErrLim);
    if (v < -ErrLim) return 27'(-ErrLim);
    return 27'(v);
  endfunction

  // omega * dt rescaled to Q.30, symmetric clamp.
  function automatic logic signed [31:0] theta(wide_t p);
    wide_t v;
    if (ThShift > 0) v = rnd(p, ThDown);
    else v = p <<< ThUp;
    if (v > Max31) return 32'sh7fff_ffff;
    if (v < -Max31) return 32'sh8000_0001;
    return 32'(v);
  endfunction

endpackage

`default_nettype wire

@@ design/dcm_attitude_update.sv @@
// From an accepted request to out_valid_o: 75 multiply steps, each an issue and a
// write-back phase on the shared 41x33 multiplier, with a matrix copy state
// between the update and renormalization steps, then the output register load.
// A new request is taken only once the last has left ST_DONE; the input stalls while a
// request is in work; the finished matrix waits only while the prior result is unread.
// Reset (rst_ni low, async): matrix to identity, filter, drift and output cleared.
// ----------------------------------------------------------------------------
// dcm_attitude_update
// DCM attitude filter step: gyro integration, renormalization and roll/pitch
// drift correction, all on one shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dcm_attitude_update (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dcm_pkg::in_req_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output dcm_pkg::out_rsp_t     out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i
);

  // Sequencer
  dcm_pkg::st_e        state_q;
  dcm_pkg::step_t      step_q;
  logic                phase_q;   // 0: issue multiply, 1: write back

  // Configuration
  logic [31:0]         gg_q, kp_q, ki_q;
  logic [15:0]         sp_q;

  // Filter state
  logic signed [31:0]  m_q [9];
  logic signed [39:0]  fa_q [3];
  logic signed [39:0]  dp_q [3];
  logic signed [39:0]  di_q [3];

  // Request and working registers
  logic signed [15:0]  g_q [3];
  logic signed [15:0]  a_q [3];
  logic signed [31:0]  th_q [3];
  logic signed [31:0]  t_q [9];
  logic signed [31:0]  err_q, r_q;
  logic signed [39:0]  om_q;
  logic signed [26:0]  c_q [3];
  logic signed [73:0]  p_q;
  dcm_pkg::wide_t      acc_q;

  // Output register
  dcm_pkg::out_rsp_t   out_q;
  logic                out_valid_q;
  logic                out_load;

  // Step decode
  dcm_pkg::seg_e       seg;
  dcm_pkg::step_t      base;
  logic [4:0]          n;
  logic [1:0]          ax, ax_sub, gk;
  logic [3:0]          upd_e, upd_rb, nrm_rb, nrm_idx;
  logic [1:0]          upd_col, kk, thx;
  logic                neg;
  logic [2:0]          nrm_sub;
  logic [3:0]          ca, cb;
  logic [1:0]          ea;
  logic [3:0]          eb;
  logic signed [40:0]  op_a;
  logic signed [32:0]  op_b;
  dcm_pkg::wide_t      pw, p30;

  // Segment of the current step
  always_comb begin
    seg  = dcm_pkg::SEG_AX;
    base = dcm_pkg::StepAx;
    if (step_q >= dcm_pkg::StepGain) begin
      seg = dcm_pkg::SEG_GAIN; base = dcm_pkg::StepGain;
    end else if (step_q >= dcm_pkg::StepEc) begin
      seg = dcm_pkg::SEG_EC;   base = dcm_pkg::StepEc;
    end else if (step_q >= dcm_pkg::StepNrm) begin
      seg = dcm_pkg::SEG_NRM;  base = dcm_pkg::StepNrm;
    end else if (step_q >= dcm_pkg::StepCrs) begin
      seg = dcm_pkg::SEG_CRS;  base = dcm_pkg::StepCrs;
    end else if (step_q >= dcm_pkg::StepRow) begin
      seg = dcm_pkg::SEG_ROW;  base = dcm_pkg::StepRow;
    end else if (step_q >= dcm_pkg::StepErr) begin
      seg = dcm_pkg::SEG_ERR;  base = dcm_pkg::StepErr;
    end else if (step_q >= dcm_pkg::StepUpd) begin
      seg = dcm_pkg::SEG_UPD;  base = dcm_pkg::StepUpd;
    end
    n = 5'(step_q - base);
  end

  // Index tables
  always_comb begin
    ax      = step_q[3:2];
    ax_sub  = step_q[1:0];
    gk      = n[2:1];
    upd_e   = n[4:1];
    upd_rb  = (upd_e >= 4'd6) ? 4'd6 : ((upd_e >= 4'd3) ? 4'd3 : 4'd0);
    upd_col = 2'(upd_e - upd_rb);
    nrm_rb  = (n >= 5'd12) ? 4'd6 : ((n >= 5'd6) ? 4'd3 : 4'd0);
    nrm_sub = 3'(n - {nrm_rb, 1'b0});
    nrm_idx = nrm_rb + 4'((nrm_sub < 3'd3) ? nrm_sub : nrm_sub - 3'd3);

    // M * skew(theta): the two nonzero terms of each element
    case ({upd_col, n[0]})
      3'b000:  begin kk = 2'd1; thx = 2'd2; neg = 1'b0; end
      3'b001:  begin kk = 2'd2; thx = 2'd1; neg = 1'b1; end
      3'b010:  begin kk = 2'd0; thx = 2'd2; neg = 1'b1; end
      3'b011:  begin kk = 2'd2; thx = 2'd0; neg = 1'b0; end
      3'b100:  begin kk = 2'd0; thx = 2'd1; neg = 1'b0; end
      3'b101:  begin kk = 2'd1; thx = 2'd0; neg = 1'b1; end
      default: begin kk = 2'd0; thx = 2'd0; neg = 1'b0; end
    endcase

    // row 2 = row 0 x row 1
    case (n[2:0])
      3'd0:    begin ca = 4'd1; cb = 4'd5; end
      3'd1:    begin ca = 4'd2; cb = 4'd4; end
      3'd2:    begin ca = 4'd2; cb = 4'd3; end
      3'd3:    begin ca = 4'd0; cb = 4'd5; end
      3'd4:    begin ca = 4'd0; cb = 4'd4; end
      3'd5:    begin ca = 4'd1; cb = 4'd3; end
      default: begin ca = 4'd0; cb = 4'd0; end
    endcase

    // accel x row 2
    case (n[2:0])
      3'd0:    begin ea = 2'd1; eb = 4'd8; end
      3'd1:    begin ea = 2'd2; eb = 4'd7; end
      3'd2:    begin ea = 2'd2; eb = 4'd6; end
      3'd3:    begin ea = 2'd0; eb = 4'd8; end
      3'd4:    begin ea = 2'd0; eb = 4'd7; end
      3'd5:    begin ea = 2'd1; eb = 4'd6; end
      default: begin ea = 2'd0; eb = 4'd6; end
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (seg)
      dcm_pkg::SEG_AX: begin
        case (ax_sub)
          2'd0: begin op_a = 41'(fa_q[ax]); op_b = dcm_pkg::FiltOld; end
          2'd1: begin op_a = 41'(a_q[ax]);  op_b = dcm_pkg::FiltNew; end
          2'd2: begin op_a = 41'(g_q[ax]);  op_b = $signed({1'b0, gg_q}); end
          default: begin op_a = 41'(om_q);  op_b = $signed({17'd0, sp_q}); end
        endcase
      end
      dcm_pkg::SEG_UPD: begin
        op_a = 41'(m_q[upd_rb + 4'(kk)]);
        op_b = neg ? -33'(th_q[thx]) : 33'(th_q[thx]);
      end
      dcm_pkg::SEG_ERR: begin
        op_a = 41'(m_q[n[3:0]]);
        op_b = 33'(m_q[n[3:0] + 4'd3]);
      end
      dcm_pkg::SEG_ROW: begin
        op_a = 41'(err_q);
        op_b = 33'(m_q[(n < 5'd3) ? n[3:0] + 4'd3 : n[3:0] - 4'd3]);
      end
      dcm_pkg::SEG_CRS: begin
        op_a = 41'(t_q[ca]);
        op_b = 33'(t_q[cb]);
      end
      dcm_pkg::SEG_NRM: begin
        op_a = 41'(t_q[nrm_idx]);
        op_b = (nrm_sub < 3'd3) ? 33'(t_q[nrm_idx]) : 33'(r_q);
      end
      dcm_pkg::SEG_EC: begin
        op_a = 41'(fa_q[ea]);
        op_b = 33'(m_q[eb]);
      end
      dcm_pkg::SEG_GAIN: begin
        op_a = 41'(c_q[gk]);
        op_b = n[0] ? $signed({1'b0, ki_q}) : $signed({1'b0, kp_q});
      end
      default: ;
    endcase
  end

  assign pw  = 80'(p_q);
  assign p30 = dcm_pkg::rnd(pw, 30);

  // finished matrix moves to the output register once that register is free
  assign out_load = (state_q == dcm_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcm_pkg::ST_IDLE;
      step_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      case (state_q)
        dcm_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= dcm_pkg::ST_MUL;
            step_q  <= '0;
            phase_q <= 1'b0;
          end
        end
        dcm_pkg::ST_MUL: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            if (step_q == dcm_pkg::StepLast) begin
              state_q <= dcm_pkg::ST_DONE;
            end else begin
              step_q <= step_q + 7'd1;
              // updated matrix goes into M before renormalization
              if (step_q == dcm_pkg::StepErr - 7'd1) state_q <= dcm_pkg::ST_COPY;
            end
          end
        end
        dcm_pkg::ST_COPY: state_q <= dcm_pkg::ST_MUL;
        dcm_pkg::ST_DONE: begin
          if (out_load) state_q <= dcm_pkg::ST_IDLE;
        end
        default: state_q <= dcm_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q <= {m_q[0], m_q[1], m_q[2], m_q[3], m_q[4], m_q[5], m_q[6], m_q[7], m_q[8]};
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gg_q <= 32'd5247220;
      sp_q <= 16'd1311;
      kp_q <= 32'd6012954;
      ki_q <= 32'd644;
      for (int k = 0; k < 9; k++) begin
        m_q[k] <= (k % 4 == 0) ? 32'sh4000_0000 : 32'sh0;
      end
      for (int k = 0; k < 3; k++) begin
        fa_q[k] <= '0;
        dp_q[k] <= '0;
        di_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dcm_pkg::CFG_GYRO_GAIN:     gg_q <= cfg_data_i;
          dcm_pkg::CFG_SAMPLE_PERIOD: sp_q <= cfg_data_i[15:0];
          dcm_pkg::CFG_KP:            kp_q <= cfg_data_i;
          dcm_pkg::CFG_KI:            ki_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == dcm_pkg::ST_COPY) begin
        for (int k = 0; k < 9; k++) m_q[k] <= t_q[k];
      end
      if (state_q == dcm_pkg::ST_MUL && phase_q) begin
        case (seg)
          dcm_pkg::SEG_AX: begin
            // f = 0.6 f + 0.4 a, Q.16
            if (ax_sub == 2'd1) fa_q[ax] <= 40'(dcm_pkg::rnd(acc_q + (pw <<< 16), 16));
          end
          dcm_pkg::SEG_NRM: begin
            if (nrm_sub >= 3'd3) m_q[nrm_idx] <= dcm_pkg::sat32(p30);
          end
          dcm_pkg::SEG_GAIN: begin
            if (!n[0]) dp_q[gk] <= 40'(dcm_pkg::rnd(pw, 32));
            else di_q[gk] <= dcm_pkg::sat40(80'(di_q[gk]) + dcm_pkg::rnd(pw, 32));
          end
          default: ;
        endcase
      end
    end
  end

  // Request capture, product register and temporaries
  always_ff @(posedge clk_i) begin
    if (state_q == dcm_pkg::ST_IDLE && in_valid_i) begin
      g_q[0] <= in_data_i.gyro_x;
      g_q[1] <= in_data_i.gyro_y;
      g_q[2] <= in_data_i.gyro_z;
      a_q[0] <= in_data_i.accel_x;
      a_q[1] <= in_data_i.accel_y;
      a_q[2] <= in_data_i.accel_z;
    end
    if (state_q == dcm_pkg::ST_MUL) begin
      if (!phase_q) begin
        p_q <= op_a * op_b;
      end else begin
        case (seg)
          dcm_pkg::SEG_AX: begin
            case (ax_sub)
              2'd0: acc_q <= pw;
              2'd2: om_q  <= dcm_pkg::sat40(dcm_pkg::rnd(pw, 16) + 80'(di_q[ax])
                                            + 80'(dp_q[ax]));
              2'd3: th_q[ax] <= dcm_pkg::theta(pw);
              default: ;
            endcase
          end
          dcm_pkg::SEG_UPD: begin
            // both terms summed before one rounding
            if (!n[0]) acc_q <= pw;
            else t_q[upd_e] <= dcm_pkg::sat32(80'(m_q[upd_e])
                                              + dcm_pkg::rnd(acc_q + pw, 30));
          end
          dcm_pkg::SEG_ERR: begin
            if (n == 5'd2) err_q <= dcm_pkg::sat32(dcm_pkg::rnd(-(acc_q + p30), 1));
            else acc_q <= ((n == 5'd0) ? '0 : acc_q) + p30;
          end
          dcm_pkg::SEG_ROW: begin
            t_q[n[3:0]] <= dcm_pkg::sat32(80'(m_q[n[3:0]]) + p30);
          end
          dcm_pkg::SEG_CRS: begin
            if (!n[0]) acc_q <= p30;
            else t_q[4'd6 + 4'(gk)] <= dcm_pkg::sat32(acc_q - p30);
          end
          dcm_pkg::SEG_NRM: begin
            case (nrm_sub)
              3'd0: acc_q <= p30;
              3'd1: acc_q <= acc_q + p30;
              3'd2: r_q <= dcm_pkg::sat32(dcm_pkg::rnd(dcm_pkg::Three30 - (acc_q + p30), 1));
              default: ;
            endcase
          end
          dcm_pkg::SEG_EC: begin
            if (!n[0]) acc_q <= p30;
            else c_q[gk] <= dcm_pkg::clamp_err(acc_q - p30);
          end
          default: ;
        endcase
      end
    end
  end

  assign in_stall_o  = (state_q != dcm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DCM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result dropped")
  `DCM_ASSERT(a_start_clean, (in_valid_i && !in_stall_o) |=> (step_q == '0) && !phase_q, "bad start")
  `DCM_ASSERT(a_done_after_last, $rose(out_valid_o) |-> ($past(step_q) == dcm_pkg::StepLast), "early result")
  `DCM_ASSERT(a_step_range, step_q <= dcm_pkg::StepLast, "step out of range")
  `DCM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == dcm_pkg::ST_IDLE), "not idle in reset")

endmodule

`default_nettype wire
